/* hdl/slq_pkg.sv */
`timescale 1ns / 1ps

package slq_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int PROG_LEN_W  = 17;
    localparam int CYCLE_W     = 32;
    localparam int CD_W        = 2;
    localparam int PC_STEP     = 3;

    localparam logic [PROG_LEN_W-1:0] PROG_LEN_RESET    = 17'h10000;
    localparam logic [CYCLE_W-1:0]    CYCLE_LIMIT_RESET = 32'd20;
    localparam logic [CD_W-1:0]       UNCOND_SKIP_LOAD  = 2'd2;
    localparam logic [CD_W-1:0]       COND_SKIP_LOAD    = 2'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROGRAM_LENGTH = 1'b0,
        CFG_CYCLE_LIMIT    = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FWD_NONE = 2'd0,
        FWD_A    = 2'd1,
        FWD_B    = 2'd2
    } fwd_code_t;

    typedef struct packed {
        logic      done_res;
        fwd_code_t forward_code;
        logic      write_enable;
    } slq_flags_t;

endpackage

/* hdl/slq_in_stage.sv */
`timescale 1ns / 1ps

module slq_in_stage #(
    parameter int DATA_W = 112
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_data,
    input  logic              advance,
    output logic              valid,
    output logic [DATA_W-1:0] data
);

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;

    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* hdl/slq_exec.sv */
`timescale 1ns / 1ps

module slq_exec #(
    parameter int ADDR_WIDTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [slq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [slq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             advance,
    input  logic [ADDR_WIDTH-1:0]            instr_a,
    input  logic [ADDR_WIDTH-1:0]            instr_b,
    input  logic [ADDR_WIDTH-1:0]            instr_c,
    input  logic [DATA_WIDTH-1:0]            data_a,
    input  logic [DATA_WIDTH-1:0]            data_b,
    output logic [ADDR_WIDTH-1:0]            item_pc,
    output logic [ADDR_WIDTH-1:0]            write_addr,
    output logic [DATA_WIDTH-1:0]            write_data,
    output logic [ADDR_WIDTH-1:0]            next_pc,
    output slq_pkg::slq_flags_t              flags
);

    localparam int CMP_W = (ADDR_WIDTH > slq_pkg::PROG_LEN_W) ? ADDR_WIDTH
                                                               : slq_pkg::PROG_LEN_W;
    localparam logic [slq_pkg::CYCLE_W-1:0] CYCLE_MAX = '1;

    logic [slq_pkg::PROG_LEN_W-1:0] prog_len_reg;
    logic [slq_pkg::CYCLE_W-1:0]    cycle_limit_reg;

    logic [ADDR_WIDTH-1:0]      pc_reg,          pc_next;
    logic [slq_pkg::CD_W-1:0]   uc_reg,          uc_next;
    logic [slq_pkg::CD_W-1:0]   cc_reg,          cc_next;
    logic [ADDR_WIDTH-1:0]      ut_reg,          ut_next;
    logic [ADDR_WIDTH-1:0]      ct_reg,          ct_next;
    logic [ADDR_WIDTH-1:0]      pwa0_reg;
    logic [ADDR_WIDTH-1:0]      pwa1_reg;
    logic [ADDR_WIDTH-1:0]      pra_reg;
    logic [ADDR_WIDTH-1:0]      prb_reg;
    logic [slq_pkg::CYCLE_W-1:0] cnt_reg,        cnt_next;

    logic [ADDR_WIDTH-1:0]    fall;
    logic [DATA_WIDTH-1:0]    diff;
    logic                     nonpos;
    logic [slq_pkg::CD_W-1:0] uc_dec;
    logic [slq_pkg::CD_W-1:0] cc_dec;
    logic                     quiet;
    logic                     take_u;
    logic                     take_c;
    logic [slq_pkg::CD_W-1:0] uc_mid;
    logic [slq_pkg::CD_W-1:0] cc_mid;
    slq_pkg::fwd_code_t       fwd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_len_reg    <= slq_pkg::PROG_LEN_RESET;
            cycle_limit_reg <= slq_pkg::CYCLE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                slq_pkg::CFG_PROGRAM_LENGTH:
                begin
                    prog_len_reg <= cfg_wdata[slq_pkg::PROG_LEN_W-1:0];
                end
                slq_pkg::CFG_CYCLE_LIMIT:
                begin
                    cycle_limit_reg <= cfg_wdata[slq_pkg::CYCLE_W-1:0];
                end
                default:
                begin
                    prog_len_reg <= prog_len_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        fall   = pc_reg + ADDR_WIDTH'(slq_pkg::PC_STEP);
        diff   = data_b - data_a;
        nonpos = (diff == '0) || diff[DATA_WIDTH-1];

        uc_dec = (uc_reg == '0) ? uc_reg : uc_reg - 1'b1;
        cc_dec = (cc_reg == '0) ? cc_reg : cc_reg - 1'b1;
        quiet  = (uc_dec == '0) && (cc_dec == '0);

        take_u = (instr_a == instr_b) && (instr_c != fall) && quiet;
        take_c = nonpos && (instr_c != fall) && quiet && !take_u;

        uc_mid  = take_u ? slq_pkg::UNCOND_SKIP_LOAD : uc_dec;
        ut_next = take_u ? instr_c : ut_reg;
        cc_mid  = take_c ? slq_pkg::COND_SKIP_LOAD : cc_dec;
        ct_next = take_c ? instr_c : ct_reg;

        flags.write_enable = !((uc_mid == 2'd1) || (cc_mid == 2'd1) || (cc_mid == 2'd2));

        fwd = slq_pkg::FWD_NONE;
        if ((pwa0_reg == instr_a) || (pwa1_reg == instr_a) || (pwa1_reg == pra_reg))
        begin
            fwd = slq_pkg::FWD_A;
        end
        if ((pwa0_reg == instr_b) || (pwa1_reg == instr_b) || (pwa1_reg == prb_reg))
        begin
            fwd = slq_pkg::FWD_B;
        end
        flags.forward_code = fwd;

        cc_next = cc_mid;
        uc_next = uc_mid;
        if (cc_mid == 2'd1)
        begin
            pc_next = ct_next;
            uc_next = '0;
        end
        else if (uc_mid == 2'd1)
        begin
            pc_next = ut_next;
        end
        else
        begin
            pc_next = fall;
        end

        cnt_next = (cnt_reg == CYCLE_MAX) ? cnt_reg : cnt_reg + 1'b1;

        flags.done_res = (CMP_W'(pc_next) >= CMP_W'(prog_len_reg))
                      || (cnt_next >= cycle_limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            uc_reg   <= '0;
            cc_reg   <= '0;
            ut_reg   <= '0;
            ct_reg   <= '0;
            pwa0_reg <= '0;
            pwa1_reg <= '0;
            pra_reg  <= '0;
            prb_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (advance)
        begin
            pc_reg   <= pc_next;
            uc_reg   <= uc_next;
            cc_reg   <= cc_next;
            ut_reg   <= ut_next;
            ct_reg   <= ct_next;
            pwa0_reg <= instr_b;
            pwa1_reg <= pwa0_reg;
            pra_reg  <= instr_a;
            prb_reg  <= instr_b;
            cnt_reg  <= cnt_next;
        end
    end

    assign item_pc    = pc_reg;
    assign write_addr = instr_b;
    assign write_data = diff;
    assign next_pc    = pc_next;

endmodule

/* hdl/slq_out_stage.sv */
`timescale 1ns / 1ps

module slq_out_stage #(
    parameter int DATA_W = 88
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [DATA_W-1:0] load_data,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata
);

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] data_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

/* hdl/subleq_pipeline_control_top.sv */
`timescale 1ns / 1ps

// Execute and branch control core of a pipelined subleq processor.
// Slave stream: one beat per fetched instruction, carrying the operand
// addresses a, b, c and the memory words read at a and b.
// Master stream: one beat per instruction, carrying its pc, the write of
// m[b] - m[a] with its enable, the forwarding code, the next fetch address
// and the done flag (pc past the program or cycle limit reached).
// Config port: write program_length (index 0) or cycle_limit (index 1)
// while no beat is in flight.
// An accepted input beat is held in the input register, then passes through
// the pc, branch countdown and forwarding logic into the output register.
// Throughput is one instruction per cycle while the receiver does not stall,
// with pc and the countdowns fed back through their own registers.
// Reset clears pc, countdowns, history and cycle count, sets program_length
// to 65536 and cycle_limit to 20, and empties both registers.
// When the receiver stalls the output beat holds, the input register still
// takes one more beat if it was empty, then s_tready drops until the output drains.
module subleq_pipeline_control_top #(
    parameter int ADDR_WIDTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [slq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [slq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // instr_a, instr_b, instr_c, data_a, data_b, zero fill
    input  logic [((3*ADDR_WIDTH+2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // item_pc, write_enable, write_addr, write_data, forward_code, next_pc,
    // done_res, zero fill
    output logic [((3*ADDR_WIDTH+DATA_WIDTH+4+7)/8)*8-1:0] m_tdata
);

    localparam int IN_BITS     = 3*ADDR_WIDTH + 2*DATA_WIDTH;
    localparam int OUT_BITS    = 3*ADDR_WIDTH + DATA_WIDTH + 4;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    logic                  in_valid;
    logic [IN_BITS-1:0]    in_data;
    logic                  out_free;
    logic                  advance;
    logic [ADDR_WIDTH-1:0] item_pc;
    logic [ADDR_WIDTH-1:0] write_addr;
    logic [DATA_WIDTH-1:0] write_data;
    logic [ADDR_WIDTH-1:0] next_pc;
    slq_pkg::slq_flags_t   flags;
    logic [OUT_BITS-1:0]   out_bits;

    assign advance = in_valid && out_free;

    slq_in_stage #(
        .DATA_W (IN_BITS)
    ) u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_data   (s_tdata[IN_BITS-1:0]),
        .advance  (advance),
        .valid    (in_valid),
        .data     (in_data)
    );

    slq_exec #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .advance    (advance),
        .instr_a    (in_data[0 +: ADDR_WIDTH]),
        .instr_b    (in_data[ADDR_WIDTH +: ADDR_WIDTH]),
        .instr_c    (in_data[2*ADDR_WIDTH +: ADDR_WIDTH]),
        .data_a     (in_data[3*ADDR_WIDTH +: DATA_WIDTH]),
        .data_b     (in_data[3*ADDR_WIDTH+DATA_WIDTH +: DATA_WIDTH]),
        .item_pc    (item_pc),
        .write_addr (write_addr),
        .write_data (write_data),
        .next_pc    (next_pc),
        .flags      (flags)
    );

    assign out_bits = {flags.done_res, next_pc, flags.forward_code, write_data,
                       write_addr, flags.write_enable, item_pc};

    slq_out_stage #(
        .DATA_W (OUT_TDATA_W)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .load_data (OUT_TDATA_W'(out_bits)),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* hdl/slq_checker.sv */
`timescale 1ns / 1ps

module slq_checker #(
    parameter int ADDR_WIDTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input logic                                           clk,
    input logic                                           rst_n,
    input logic                                           s_tready,
    input logic                                           m_tvalid,
    input logic                                           m_tready,
    input logic [((3*ADDR_WIDTH+DATA_WIDTH+4+7)/8)*8-1:0] m_tdata
);

    localparam int WE_BIT = ADDR_WIDTH;
    localparam int NP_LSB = 2*ADDR_WIDTH + DATA_WIDTH + 3;

    logic                  out_beat;
    logic [ADDR_WIDTH-1:0] beat_pc;
    logic [ADDR_WIDTH-1:0] beat_next;
    logic [ADDR_WIDTH-1:0] beat_fall;

    assign out_beat  = m_tvalid && m_tready;
    assign beat_pc   = m_tdata[0 +: ADDR_WIDTH];
    assign beat_next = m_tdata[NP_LSB +: ADDR_WIDTH];
    assign beat_fall = beat_pc + ADDR_WIDTH'(slq_pkg::PC_STEP);

    a_empty_after_reset : assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output beat present straight out of reset");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

    a_no_needless_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output side is free");

    a_pc_chain : assert property (@(posedge clk) disable iff (!rst_n)
        out_beat ##1 out_beat |-> beat_pc == $past(beat_next))
        else $error("consecutive beats break the pc chain");

    a_redirect_suppressed : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (beat_next != beat_fall) |-> !m_tdata[WE_BIT])
        else $error("branch redirect on a beat that still writes");

endmodule

bind subleq_pipeline_control_top slq_checker #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_slq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
